>>> sv/swpb_pkg.sv
package swpb_pkg;

  localparam int ADDR_W  = 24;
  localparam int PIX_W   = 8;
  localparam int SCALE_W = 4;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 11;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 3;
  localparam int X_W     = 15;
  localparam int Y_W     = 16;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE         = 3'd7;

  localparam logic [10:0] RST_SOURCE_WIDTH  = 11'd320;
  localparam logic [10:0] RST_WINDOW_WIDTH  = 11'd320;
  localparam logic [10:0] RST_WINDOW_HEIGHT = 11'd200;
  localparam logic [SCALE_W-1:0] RST_SCALE  = 4'd1;

  localparam logic [COL_W-1:0] COL_MAX = 10'd1023;
  localparam logic [ROW_W-1:0] ROW_MAX = 11'd2047;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             first;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_addr;
    logic [PIX_W-1:0]  write_value;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base_addr;
    logic [PIX_W-1:0]   pixel;
    logic [SCALE_W-1:0] scale;
  } blit_job_t;

endpackage

>>> sv/swpb_front.sv
module swpb_front #(
  parameter int LINE_PITCH = 640,
  parameter int MAX_SCALE  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swpb_pkg::in_word_t              in_data,
  input  logic                            cfg_we,
  input  logic [swpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swpb_pkg::CFG_W-1:0]      cfg_data,
  input  logic [swpb_pkg::QCNT_W-1:0]     q_count,
  output logic                            push,
  output swpb_pkg::blit_job_t             push_data
);

  logic [10:0] source_width_r;
  logic [9:0]  window_x_r;
  logic [9:0]  window_y_r;
  logic [10:0] window_width_r;
  logic [10:0] window_height_r;
  logic [11:0] target_x_r;
  logic [11:0] target_y_r;
  logic [swpb_pkg::SCALE_W-1:0] scale_r;

  logic [swpb_pkg::COL_W-1:0] col_r, col_nxt, col;
  logic [swpb_pkg::ROW_W-1:0] row_r, row_nxt, row;

  logic                          s1_vld_r, s1_vld_nxt;
  logic [swpb_pkg::PIX_W-1:0]    s1_pix_r;
  logic [swpb_pkg::SCALE_W-1:0]  s1_sc_r;
  logic [swpb_pkg::X_W-1:0]      s1_x_r, x_nxt;
  logic [swpb_pkg::Y_W-1:0]      s1_y_r, y_nxt;

  logic [swpb_pkg::QCNT_W:0]     occ;
  logic                          accept;
  logic [11:0]                   x_end, y_end;
  logic                          in_win;
  logic [swpb_pkg::COL_W-1:0]    i_off;
  logic [swpb_pkg::ROW_W-1:0]    j_off;
  logic [swpb_pkg::SCALE_W-1:0]  sc_sat;
  logic                          row_done;

  assign occ      = {1'b0, q_count} + {{swpb_pkg::QCNT_W{1'b0}}, s1_vld_r};
  assign in_ready = occ < (swpb_pkg::QCNT_W + 1)'(swpb_pkg::QDEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    col    = in_data.first ? '0 : col_r;
    row    = in_data.first ? '0 : row_r;
    x_end  = {2'b00, window_x_r} + {1'b0, window_width_r};
    y_end  = {2'b00, window_y_r} + {1'b0, window_height_r};
    in_win = ({2'b00, col} >= {2'b00, window_x_r}) && ({2'b00, col} < x_end) &&
             ({1'b0, row} >= {2'b00, window_y_r}) && ({1'b0, row} < y_end);
    i_off  = col - window_x_r;
    j_off  = row - {1'b0, window_y_r};
    sc_sat = (scale_r > swpb_pkg::SCALE_W'(MAX_SCALE)) ?
             swpb_pkg::SCALE_W'(MAX_SCALE) : scale_r;
    x_nxt  = swpb_pkg::X_W'(target_x_r) +
             swpb_pkg::X_W'(i_off) * swpb_pkg::X_W'(sc_sat);
    y_nxt  = swpb_pkg::Y_W'(target_y_r) +
             swpb_pkg::Y_W'(j_off) * swpb_pkg::Y_W'(sc_sat);
    row_done = ({1'b0, col} + 11'd1 >= source_width_r) || (col == swpb_pkg::COL_MAX);

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_done) begin
        col_nxt = '0;
        row_nxt = (row < swpb_pkg::ROW_MAX) ? row + 11'd1 : row;
      end else begin
        col_nxt = col + 10'd1;
        row_nxt = row;
      end
    end
    s1_vld_nxt = accept && in_win && (sc_sat != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_width_r  <= swpb_pkg::RST_SOURCE_WIDTH;
      window_x_r      <= '0;
      window_y_r      <= '0;
      window_width_r  <= swpb_pkg::RST_WINDOW_WIDTH;
      window_height_r <= swpb_pkg::RST_WINDOW_HEIGHT;
      target_x_r      <= '0;
      target_y_r      <= '0;
      scale_r         <= swpb_pkg::RST_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swpb_pkg::CFG_SOURCE_WIDTH:  source_width_r  <= cfg_data[10:0];
        swpb_pkg::CFG_WINDOW_X:      window_x_r      <= cfg_data[9:0];
        swpb_pkg::CFG_WINDOW_Y:      window_y_r      <= cfg_data[9:0];
        swpb_pkg::CFG_WINDOW_WIDTH:  window_width_r  <= cfg_data[10:0];
        swpb_pkg::CFG_WINDOW_HEIGHT: window_height_r <= cfg_data[10:0];
        swpb_pkg::CFG_TARGET_X:      target_x_r      <= cfg_data[11:0];
        swpb_pkg::CFG_TARGET_Y:      target_y_r      <= cfg_data[11:0];
        swpb_pkg::CFG_SCALE:         scale_r         <= cfg_data[3:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_nxt) begin
      s1_pix_r <= in_data.pixel;
      s1_sc_r  <= sc_sat;
      s1_x_r   <= x_nxt;
      s1_y_r   <= y_nxt;
    end
  end

  assign push                = s1_vld_r;
  assign push_data.base_addr = swpb_pkg::ADDR_W'(s1_y_r) * swpb_pkg::ADDR_W'(LINE_PITCH) +
                               swpb_pkg::ADDR_W'(s1_x_r);
  assign push_data.pixel     = s1_pix_r;
  assign push_data.scale     = s1_sc_r;

endmodule

>>> sv/swpb_queue.sv
module swpb_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  swpb_pkg::blit_job_t          push_data,
  input  logic                         pop,
  output swpb_pkg::blit_job_t          pop_data,
  output logic                         nonempty,
  output logic [swpb_pkg::QCNT_W-1:0]  count
);

  swpb_pkg::blit_job_t               mem_r [swpb_pkg::QDEPTH];
  logic [swpb_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [swpb_pkg::QCNT_W-1:0]       count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign nonempty = count_r != '0;
  assign count    = count_r;

endmodule

>>> sv/swpb_back.sv
module swpb_back #(
  parameter int LINE_PITCH = 640,
  parameter int MAX_SCALE  = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_nonempty,
  input  swpb_pkg::blit_job_t  q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output swpb_pkg::out_word_t  out_data
);

  localparam int SW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic                           busy_r, busy_nxt;
  logic [swpb_pkg::ADDR_W-1:0]    row_base_r, row_base_nxt;
  logic [SW-1:0]                  n_r, n_nxt, m_r, m_nxt;
  logic [swpb_pkg::SCALE_W-1:0]   sc_r, sc_nxt;
  logic [swpb_pkg::PIX_W-1:0]     pix_r, pix_nxt;
  logic                           out_vld_r, out_vld_nxt;
  swpb_pkg::out_word_t            out_r, out_nxt;

  logic emit, n_end, m_end;

  always_comb begin
    emit  = busy_r && (!out_vld_r || out_ready);
    n_end = swpb_pkg::SCALE_W'(n_r) == sc_r - 4'd1;
    m_end = swpb_pkg::SCALE_W'(m_r) == sc_r - 4'd1;
    pop   = q_nonempty && (!busy_r || (emit && n_end && m_end));

    busy_nxt     = busy_r;
    row_base_nxt = row_base_r;
    n_nxt        = n_r;
    m_nxt        = m_r;
    sc_nxt       = sc_r;
    pix_nxt      = pix_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_ready;

    if (emit) begin
      out_vld_nxt         = 1'b1;
      out_nxt.write_addr  = row_base_r + swpb_pkg::ADDR_W'(n_r);
      out_nxt.write_value = pix_r;
      out_nxt.last        = n_end && m_end;
      if (n_end) begin
        n_nxt        = '0;
        m_nxt        = m_r + 1'b1;
        row_base_nxt = row_base_r + swpb_pkg::ADDR_W'(LINE_PITCH);
        if (m_end) busy_nxt = 1'b0;
      end else begin
        n_nxt = n_r + 1'b1;
      end
    end

    if (pop) begin
      busy_nxt     = 1'b1;
      row_base_nxt = q_data.base_addr;
      n_nxt        = '0;
      m_nxt        = '0;
      sc_nxt       = q_data.scale;
      pix_nxt      = q_data.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_base_r <= row_base_nxt;
    n_r        <= n_nxt;
    m_r        <= m_nxt;
    sc_r       <= sc_nxt;
    pix_r      <= pix_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

>>> sv/scaled_window_pixel_blit.sv
// Channel   Direction  Word                         Handshake
// in_       input      pixel, first                 in_valid / in_ready
// out_      output     write_addr, write_value, last out_valid / out_ready
// cfg_      input      cfg_index, cfg_data          cfg_we, no wait
//
// The front takes one pixel a cycle while its job queue has room; pixels
// outside the window or at scale zero are dropped and never reach the queue.
// The back replication loop writes a scale by scale block for each window
// pixel, rows LINE_PITCH apart, and pops its next job with the last write.
// A pixel reaches out_ via front stage, queue, back job and output registers.
// Synchronous reset restores the register defaults and empties the queue.
// Either side may stall; the queue and the output register decouple them.
module scaled_window_pixel_blit #(
  parameter int LINE_PITCH = 640,
  parameter int MAX_SCALE  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swpb_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output swpb_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [swpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swpb_pkg::CFG_W-1:0]      cfg_data
);

  logic                            push, pop, q_nonempty;
  swpb_pkg::blit_job_t             push_data, q_data;
  logic [swpb_pkg::QCNT_W-1:0]     q_count;

  swpb_front #(
    .LINE_PITCH (LINE_PITCH),
    .MAX_SCALE  (MAX_SCALE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  swpb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .nonempty  (q_nonempty),
    .count     (q_count)
  );

  swpb_back #(
    .LINE_PITCH (LINE_PITCH),
    .MAX_SCALE  (MAX_SCALE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
